// File: design/dgsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgsp_pkg
// Shared types and constants for the dense-graph shortest-path core.
// ----------------------------------------------------------------------------
package dgsp_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int DIST_BITS_DEF    = 24;
    localparam int RESULT_LIMIT     = 16;

    localparam int VC_BITS = 5;
    localparam logic [VC_BITS-1:0] VC_RESET = 5'd16;

    typedef struct packed {
        logic [3:0]  row_vertex;
        logic [3:0]  col_vertex;
        logic [15:0] edge_weight;
        logic        last_entry;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  vertex_index;
        logic [23:0] distance;
        logic        unreached;
        logic        last_result;
    } out_item_t;

    typedef struct packed {
        logic lt;
        logic le;
    } alu_flags_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROUND_CHK,
        ST_PICK,
        ST_PICK_END,
        ST_RELAX,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } state_t;

endpackage
`default_nettype wire

// File: design/dgsp_wstore.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgsp_wstore
// Adjacency weight memory, one write and one registered read port, with a
// clearing sweep run after reset and on request.
// ----------------------------------------------------------------------------
module dgsp_wstore #(
    parameter int MAX_VERTICES = dgsp_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = dgsp_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         wr_en,
    input  wire logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0] wr_addr,
    input  wire logic [WEIGHT_BITS-1:0]                       wr_data,
    input  wire logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0] rd_addr,
    output logic      [WEIGHT_BITS-1:0]                       rd_data,
    input  wire logic                                         clr_start,
    output logic                                              clr_busy
);

    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);

    logic [WEIGHT_BITS-1:0] mem [DEPTH];
    logic [WEIGHT_BITS-1:0] rd_data_reg;
    logic                   clr_busy_reg, clr_busy_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_start) begin
            clr_busy_next = 1'b1;
            clr_addr_next = '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
            clr_addr_next = clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule
`default_nettype wire

// File: design/dgsp_dstore.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgsp_dstore
// Per-vertex distance memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module dgsp_dstore #(
    parameter int MAX_VERTICES = dgsp_pkg::MAX_VERTICES_DEF,
    parameter int DIST_BITS    = dgsp_pkg::DIST_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            wr_en,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    input  wire logic [DIST_BITS-1:0]            wr_data,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    output logic      [DIST_BITS-1:0]            rd_data
);

    logic [DIST_BITS-1:0] mem [MAX_VERTICES];
    logic [DIST_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: design/dgsp_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgsp_alu
// Shared saturating add and compare: sum = sat(base + addend), flags of
// sum against other. Used by both the minimum scan and the relaxation.
// ----------------------------------------------------------------------------
module dgsp_alu #(
    parameter int WEIGHT_BITS = dgsp_pkg::WEIGHT_BITS_DEF,
    parameter int DIST_BITS   = dgsp_pkg::DIST_BITS_DEF
) (
    input  wire logic [DIST_BITS-1:0]   base,
    input  wire logic [WEIGHT_BITS-1:0] addend,
    input  wire logic [DIST_BITS-1:0]   other,
    output logic      [DIST_BITS-1:0]   sum,
    output dgsp_pkg::alu_flags_t        flags
);

    localparam int SW = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
    localparam logic [DIST_BITS-1:0] DMAX = {DIST_BITS{1'b1}};

    logic [SW-1:0] sum_full;

    always_comb begin
        sum_full = SW'(base) + SW'(addend);
        sum      = (sum_full > SW'(DMAX)) ? DMAX : DIST_BITS'(sum_full);
        flags.lt = (sum < other);
        flags.le = (sum <= other);
    end

endmodule
`default_nettype wire

// File: design/dense_graph_shortest_paths_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Loading: one matrix-entry transfer per cycle while idle and no clearing sweep runs.
// Search over n vertices: one shared add/compare unit scans one vertex per cycle
// for each pick and relax pass.
// Results: n transfers, each through OUT_RD, OUT_WAIT and OUT_HOLD, plus output stall;
// a clearing sweep of all MAX_VERTICES^2 entries runs after reset and after each search, no input meanwhile.
// Reset: aresetn synchronous active low; vertex_count resets to 16.
// ----------------------------------------------------------------------------
// dense_graph_shortest_paths_core
// Adjacency-matrix loader and iterative single-source shortest-path search.
// ----------------------------------------------------------------------------
module dense_graph_shortest_paths_core #(
    parameter int MAX_VERTICES = dgsp_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = dgsp_pkg::WEIGHT_BITS_DEF,
    parameter int DIST_BITS    = dgsp_pkg::DIST_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [4:0]            cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire dgsp_pkg::in_item_t    s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output dgsp_pkg::out_item_t        m_data
);

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int CW     = $clog2(MAX_VERTICES + 1);
    localparam int AW     = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int VLIMIT = (MAX_VERTICES < dgsp_pkg::RESULT_LIMIT) ?
                            MAX_VERTICES : dgsp_pkg::RESULT_LIMIT;
    localparam logic [DIST_BITS-1:0] DMAX = {DIST_BITS{1'b1}};

    dgsp_pkg::state_t state_reg, state_next;

    logic [4:0]              vc_reg;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           round_reg, round_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    p_vld_reg, p_vld_next;
    logic [VW-1:0]           p_idx_reg, p_idx_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] reached_reg, reached_next;
    logic                    have_reg, have_next;
    logic [VW-1:0]           best_idx_reg, best_idx_next;
    logic                    best_rch_reg, best_rch_next;
    logic [DIST_BITS-1:0]    best_d_reg, best_d_next;
    dgsp_pkg::out_item_t     out_reg, out_next;

    logic                    s_acc;
    logic [4:0]              n_act;
    logic                    rounds_done;
    logic                    scan_done;
    logic                    in_range;

    logic                    w_wr_en;
    logic [AW-1:0]           w_wr_addr;
    logic [AW-1:0]           w_rd_addr;
    logic [WEIGHT_BITS-1:0]  w_rd_data;
    logic                    clr_start;
    logic                    clr_busy;

    logic                    d_wr_en;
    logic [VW-1:0]           d_wr_addr;
    logic [DIST_BITS-1:0]    d_wr_data;
    logic [DIST_BITS-1:0]    d_rd_data;

    logic [DIST_BITS-1:0]    alu_base;
    logic [WEIGHT_BITS-1:0]  alu_addend;
    logic [DIST_BITS-1:0]    alu_other;
    logic [DIST_BITS-1:0]    alu_sum;
    dgsp_pkg::alu_flags_t    alu_flags;

    assign s_ready = (state_reg == dgsp_pkg::ST_IDLE) && !clr_busy;
    assign s_acc   = s_valid && s_ready;
    assign m_valid = (state_reg == dgsp_pkg::ST_OUT_HOLD);
    assign m_data  = out_reg;

    assign n_act = (vc_reg == 5'd0) ? 5'd1 :
                   (vc_reg > 5'(VLIMIT)) ? 5'(VLIMIT) : vc_reg;

    assign rounds_done = (CW'(round_reg + 1'b1) == n_reg);
    assign scan_done   = (cnt_reg == n_reg) && !p_vld_reg;

    assign in_range  = (int'(s_data.row_vertex) < MAX_VERTICES) &&
                       (int'(s_data.col_vertex) < MAX_VERTICES);
    assign w_wr_en   = s_acc && in_range;
    assign w_wr_addr = AW'(int'(s_data.row_vertex) * MAX_VERTICES
                           + int'(s_data.col_vertex));
    assign w_rd_addr = AW'(int'(best_idx_reg) * MAX_VERTICES + int'(cnt_reg[VW-1:0]));

    dgsp_wstore #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_wstore (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (w_wr_en),
        .wr_addr   (w_wr_addr),
        .wr_data   (WEIGHT_BITS'(s_data.edge_weight)),
        .rd_addr   (w_rd_addr),
        .rd_data   (w_rd_data),
        .clr_start (clr_start),
        .clr_busy  (clr_busy)
    );

    dgsp_dstore #(
        .MAX_VERTICES (MAX_VERTICES),
        .DIST_BITS    (DIST_BITS)
    ) u_dstore (
        .aclk    (aclk),
        .wr_en   (d_wr_en),
        .wr_addr (d_wr_addr),
        .wr_data (d_wr_data),
        .rd_addr (cnt_reg[VW-1:0]),
        .rd_data (d_rd_data)
    );

    always_comb begin
        if (state_reg == dgsp_pkg::ST_RELAX) begin
            alu_base   = best_d_reg;
            alu_addend = w_rd_data;
            alu_other  = d_rd_data;
        end else begin
            alu_base   = d_rd_data;
            alu_addend = '0;
            alu_other  = best_d_reg;
        end
    end

    dgsp_alu #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .DIST_BITS   (DIST_BITS)
    ) u_alu (
        .base   (alu_base),
        .addend (alu_addend),
        .other  (alu_other),
        .sum    (alu_sum),
        .flags  (alu_flags)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dgsp_pkg::ST_IDLE: begin
                if (s_acc && s_data.last_entry) begin
                    state_next = dgsp_pkg::ST_INIT;
                end
            end
            dgsp_pkg::ST_INIT: begin
                state_next = dgsp_pkg::ST_ROUND_CHK;
            end
            dgsp_pkg::ST_ROUND_CHK: begin
                state_next = rounds_done ? dgsp_pkg::ST_OUT_RD : dgsp_pkg::ST_PICK;
            end
            dgsp_pkg::ST_PICK: begin
                if (scan_done) begin
                    state_next = dgsp_pkg::ST_PICK_END;
                end
            end
            dgsp_pkg::ST_PICK_END: begin
                state_next = best_rch_reg ? dgsp_pkg::ST_RELAX : dgsp_pkg::ST_ROUND_CHK;
            end
            dgsp_pkg::ST_RELAX: begin
                if (scan_done) begin
                    state_next = dgsp_pkg::ST_ROUND_CHK;
                end
            end
            dgsp_pkg::ST_OUT_RD: begin
                state_next = dgsp_pkg::ST_OUT_WAIT;
            end
            dgsp_pkg::ST_OUT_WAIT: begin
                state_next = dgsp_pkg::ST_OUT_HOLD;
            end
            dgsp_pkg::ST_OUT_HOLD: begin
                if (m_ready) begin
                    state_next = out_reg.last_result ? dgsp_pkg::ST_IDLE
                                                     : dgsp_pkg::ST_OUT_RD;
                end
            end
            default: begin
                state_next = dgsp_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_next        = n_reg;
        round_next    = round_reg;
        cnt_next      = cnt_reg;
        p_vld_next    = 1'b0;
        p_idx_next    = p_idx_reg;
        visited_next  = visited_reg;
        reached_next  = reached_reg;
        have_next     = have_reg;
        best_idx_next = best_idx_reg;
        best_rch_next = best_rch_reg;
        best_d_next   = best_d_reg;
        out_next      = out_reg;
        clr_start     = 1'b0;
        d_wr_en       = 1'b0;
        d_wr_addr     = p_idx_reg;
        d_wr_data     = alu_sum;

        case (state_reg)
            dgsp_pkg::ST_IDLE: begin
                if (s_acc && s_data.last_entry) begin
                    n_next = CW'(n_act);
                end
            end
            dgsp_pkg::ST_INIT: begin
                visited_next = '0;
                reached_next = MAX_VERTICES'(1);
                round_next   = '0;
                d_wr_en      = 1'b1;
                d_wr_addr    = '0;
                d_wr_data    = '0;
            end
            dgsp_pkg::ST_ROUND_CHK: begin
                cnt_next  = '0;
                have_next = 1'b0;
                clr_start = rounds_done;
            end
            dgsp_pkg::ST_PICK: begin
                if (cnt_reg != n_reg) begin
                    p_vld_next = 1'b1;
                    p_idx_next = cnt_reg[VW-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                end
                if (p_vld_reg && !visited_reg[p_idx_reg]) begin
                    // unreached ranks above any distance, ties go to the later index
                    if (!have_reg || (!reached_reg[p_idx_reg] && !best_rch_reg) ||
                        (reached_reg[p_idx_reg] && (!best_rch_reg || alu_flags.le))) begin
                        have_next     = 1'b1;
                        best_idx_next = p_idx_reg;
                        best_rch_next = reached_reg[p_idx_reg];
                        best_d_next   = d_rd_data;
                    end
                end
            end
            dgsp_pkg::ST_PICK_END: begin
                visited_next[best_idx_reg] = 1'b1;
                cnt_next                   = '0;
                if (!best_rch_reg) begin
                    round_next = round_reg + 1'b1;
                end
            end
            dgsp_pkg::ST_RELAX: begin
                if (cnt_reg != n_reg) begin
                    p_vld_next = 1'b1;
                    p_idx_next = cnt_reg[VW-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                end
                if (p_vld_reg && (w_rd_data != '0) && !visited_reg[p_idx_reg] &&
                    (!reached_reg[p_idx_reg] || alu_flags.lt)) begin
                    d_wr_en                 = 1'b1;
                    reached_next[p_idx_reg] = 1'b1;
                end
                if (scan_done) begin
                    round_next = round_reg + 1'b1;
                end
            end
            dgsp_pkg::ST_OUT_RD: begin
            end
            dgsp_pkg::ST_OUT_WAIT: begin
                out_next.vertex_index = 4'(cnt_reg);
                out_next.distance     = reached_reg[cnt_reg[VW-1:0]] ? 24'(d_rd_data)
                                                                    : 24'(DMAX);
                out_next.unreached    = !reached_reg[cnt_reg[VW-1:0]];
                out_next.last_result  = (CW'(cnt_reg + 1'b1) == n_reg);
            end
            dgsp_pkg::ST_OUT_HOLD: begin
                if (m_ready) begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dgsp_pkg::ST_IDLE;
            vc_reg    <= dgsp_pkg::VC_RESET;
            p_vld_reg <= 1'b0;
            cnt_reg   <= '0;
            round_reg <= '0;
            n_reg     <= CW'(1);
            have_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                vc_reg <= cfg_wdata;
            end
            p_vld_reg <= p_vld_next;
            cnt_reg   <= cnt_next;
            round_reg <= round_next;
            n_reg     <= n_next;
            have_reg  <= have_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_idx_reg    <= p_idx_next;
        visited_reg  <= visited_next;
        reached_reg  <= reached_next;
        best_idx_reg <= best_idx_next;
        best_rch_reg <= best_rch_next;
        best_d_reg   <= best_d_next;
        out_reg      <= out_next;
    end

`ifndef SYNTH
    a_no_take_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_data.last_entry) |=> !s_ready)
        else $error("input taken right after search start");

    a_pick_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dgsp_pkg::ST_PICK_END) |-> have_reg)
        else $error("pick pass found no unvisited vertex");

    a_result_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (cnt_reg < n_reg))
        else $error("result index beyond active vertex count");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_result) |=> (state_reg == dgsp_pkg::ST_IDLE))
        else $error("sequencer not idle after final result transfer");
`endif

endmodule
`default_nettype wire

// File: test/dense_graph_shortest_paths_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_graph_shortest_paths_core_tb
// Loads hand-built and random adjacency matrices, runs searches at several
// vertex counts and flow-control patterns, and checks every reported distance
// against a behavioral shortest-path model kept inside the bench.
// ----------------------------------------------------------------------------
module dense_graph_shortest_paths_core_tb;

    localparam int LIMIT_CYCLES  = 2000000;
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASE_ITEMS   = 40;
    localparam int LONG_HOLD     = 1500;
    localparam int NV            = dgsp_pkg::MAX_VERTICES_DEF;
    localparam int VCB           = dgsp_pkg::VC_BITS;
    localparam int DB            = dgsp_pkg::DIST_BITS_DEF;
    localparam int WB            = dgsp_pkg::WEIGHT_BITS_DEF;
    localparam logic [DB-1:0] DIST_SAT = '1;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [VCB-1:0]      cfg_wdata = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    dgsp_pkg::in_item_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    dgsp_pkg::out_item_t m_data;

    dgsp_pkg::in_item_t  load_q[$];
    dgsp_pkg::out_item_t dist_expect_q[$];
    bit [WB-1:0]         edge_mem [NV*NV];
    logic [VCB-1:0]      vcount = dgsp_pkg::VC_RESET;

    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        rx_hold_req    = 0;
    int        hold_seen      = 0;
    int        hold_left      = 0;
    int        cycle_count    = 0;
    int        fault_count    = 0;
    int        entries_sent   = 0;
    int        searches_run   = 0;
    int        results_checked = 0;
    dgsp_pkg::out_item_t want;

    dense_graph_shortest_paths_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int active_vertices(input logic [VCB-1:0] vc);
        int n;
        n = int'(vc);
        if (n < 1) n = 1;
        if (n > NV) n = NV;
        if (n > dgsp_pkg::RESULT_LIMIT) n = dgsp_pkg::RESULT_LIMIT;
        return n;
    endfunction

    // Store one matrix entry; on the last entry run the search and queue the
    // expected distance report, then clear the matrix.
    function automatic void take_entry(input dgsp_pkg::in_item_t item);
        int n, best, u, i, j, round;
        bit have;
        logic [DB-1:0] dist_v [NV];
        bit reached [NV];
        bit visited [NV];
        logic [DB:0] sum;
        logic [WB-1:0] w;
        dgsp_pkg::out_item_t r;
        edge_mem[int'(item.row_vertex) * NV + int'(item.col_vertex)] = item.edge_weight;
        if (!item.last_entry) return;
        n = active_vertices(vcount);
        for (i = 0; i < NV; i++) begin
            dist_v[i] = '0;
            reached[i] = 1'b0;
            visited[i] = 1'b0;
        end
        reached[0] = 1'b1;
        for (round = 0; round + 1 < n; round++) begin
            best = 0;
            have = 1'b0;
            for (i = 0; i < n; i++) begin
                if (visited[i]) continue;
                if (!have) begin
                    best = i;
                    have = 1'b1;
                end else if (!reached[i]) begin
                    if (!reached[best]) best = i;
                end else if (!reached[best] || dist_v[i] <= dist_v[best]) begin
                    best = i;
                end
            end
            u = best;
            visited[u] = 1'b1;
            if (!reached[u]) continue;
            for (j = 0; j < n; j++) begin
                w = edge_mem[u * NV + j];
                if (w == 0 || visited[j]) continue;
                sum = {1'b0, dist_v[u]} + (DB+1)'(w);
                if (sum > {1'b0, DIST_SAT}) sum = {1'b0, DIST_SAT};
                if (!reached[j] || sum[DB-1:0] < dist_v[j]) begin
                    dist_v[j] = sum[DB-1:0];
                    reached[j] = 1'b1;
                end
            end
        end
        for (i = 0; i < n; i++) begin
            r.vertex_index = 4'(i);
            r.distance     = reached[i] ? dist_v[i] : DIST_SAT;
            r.unreached    = !reached[i];
            r.last_result  = (i + 1 == n);
            dist_expect_q.push_back(r);
        end
        for (i = 0; i < NV*NV; i++) edge_mem[i] = '0;
    endfunction

    function automatic dgsp_pkg::in_item_t make_entry(input int row, input int col,
                                                      input int w, input bit last);
        dgsp_pkg::in_item_t e;
        e.row_vertex  = 4'(row);
        e.col_vertex  = 4'(col);
        e.edge_weight = 16'(w);
        e.last_entry  = last;
        return e;
    endfunction

    function automatic int rand_weight();
        int p;
        p = $urandom_range(99);
        if (p < 10) return 0;
        if (p < 20) return 16'hFFFF;
        if (p < 60) return $urandom_range(1, 4);
        return $urandom_range(0, 65535);
    endfunction

    function automatic int rand_vertex(input int n);
        if ($urandom_range(99) < 85) return $urandom_range(0, n - 1);
        return $urandom_range(0, 15);
    endfunction

    function automatic int push_graph(input int n);
        int loads, i;
        loads = $urandom_range(0, 2*n + 2);
        for (i = 0; i < loads; i++)
            load_q.push_back(make_entry(rand_vertex(n), rand_vertex(n), rand_weight(), 1'b0));
        load_q.push_back(make_entry($urandom_range(0, 15), $urandom_range(0, 15),
                                    rand_weight(), 1'b1));
        return loads + 1;
    endfunction

    task automatic wait_drained();
        do @(negedge aclk);
        while (load_q.size() != 0 || s_valid || dist_expect_q.size() != 0);
    endtask

    task automatic set_vertex_count(input logic [VCB-1:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        vcount     = v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input bit one_at_a_time);
        int sent, n;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        n = active_vertices(vcount);
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            sent += push_graph(n);
            if (one_at_a_time) wait_drained();
        end
        wait_drained();
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                take_entry(s_data);
                entries_sent++;
                if (s_data.last_entry) searches_run++;
            end
            if (!s_valid || s_ready) begin
                if (load_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= load_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != rx_hold_req) begin
            hold_seen <= rx_hold_req;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (dist_expect_q.size() == 0) begin
                $error("unexpected result transfer for vertex %0d", m_data.vertex_index);
                fault_count++;
            end else begin
                want = dist_expect_q.pop_front();
                results_checked++;
                if (m_data.vertex_index !== want.vertex_index) begin
                    $error("vertex_index: expected %0d, got %0d",
                           want.vertex_index, m_data.vertex_index);
                    fault_count++;
                end
                if (m_data.distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, m_data.distance);
                    fault_count++;
                end
                if (m_data.unreached !== want.unreached) begin
                    $error("unreached: expected %0d, got %0d", want.unreached, m_data.unreached);
                    fault_count++;
                end
                if (m_data.last_result !== want.last_result) begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, m_data.last_result);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: ties, overwrite to no edge, unreached vertices, widest weights
        load_q.push_back(make_entry(0, 1, 1, 1'b0));
        load_q.push_back(make_entry(1, 2, 16'hFFFF, 1'b0));
        load_q.push_back(make_entry(0, 2, 16'hFFFF, 1'b0));
        load_q.push_back(make_entry(2, 15, 16'hFFFF, 1'b0));
        load_q.push_back(make_entry(0, 3, 2, 1'b0));
        load_q.push_back(make_entry(3, 4, 2, 1'b0));
        load_q.push_back(make_entry(0, 4, 4, 1'b0));
        load_q.push_back(make_entry(5, 6, 7, 1'b0));
        load_q.push_back(make_entry(0, 7, 5, 1'b0));
        load_q.push_back(make_entry(0, 7, 0, 1'b0));
        load_q.push_back(make_entry(15, 14, 3, 1'b1));
        set_vertex_count(5'd0);
        load_q.push_back(make_entry(0, 0, 9, 1'b1));
        set_vertex_count(5'd31);
        load_q.push_back(make_entry(0, 8, 10, 1'b0));
        load_q.push_back(make_entry(8, 9, 1, 1'b1));
        set_vertex_count(5'd2);
        load_q.push_back(make_entry(0, 1, 16'hFFFF, 1'b0));
        load_q.push_back(make_entry(1, 0, 1, 1'b0));
        load_q.push_back(make_entry(1, 1, 5, 1'b1));
        wait_drained();
        load_q.push_back(make_entry(1, 0, 3, 1'b1));

        // random
        set_vertex_count(5'd16);
        run_phase(0, 0, 1'b0);
        set_vertex_count(5'd5);
        run_phase(64, 0, 1'b0);
        set_vertex_count(5'd31);
        run_phase(0, 64, 1'b0);
        set_vertex_count(5'd1);
        run_phase(6, 6, 1'b0);
        set_vertex_count(5'd2);
        run_phase(0, 0, 1'b0);
        set_vertex_count(5'd16);
        rx_hold_req++;
        run_phase(0, 0, 1'b0);
        set_vertex_count(5'($urandom_range(3, 8)));
        run_phase(64, 0, 1'b1);
        set_vertex_count(5'($urandom_range(0, 31)));
        run_phase(6, 6, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d matrix entries forming %0d searches at vertex counts 0 to 31,",
                 entries_sent, searches_run);
        $display("checked %0d distance reports under idle, stall and backpressure.",
                 results_checked);
        if (fault_count == 0 && dist_expect_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
